// ===== rtl/wtf8_pkg.sv =====
// Shared types and constants for the WTF-8 byte decoder.
// Depends on nothing; every other file in rtl/ imports it.
package wtf8_pkg;

  // Byte classes that the front end assigns to each incoming byte.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_t;

  localparam int unsigned POINT_W = 21;
  localparam int unsigned BITS_W  = 7;
  localparam int unsigned REM_W   = 2;

  // Depth of the queue between the front end and the decoder back end.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // One classified byte as it travels through the queue.
  typedef struct packed {
    byte_cls_t          cls;
    logic [BITS_W-1:0]  bits;
    logic               last;
  } q_item_t;

endpackage

// ===== rtl/wtf8_byte_decoder.sv =====
// Top level of the WTF-8 byte decoder: front end, queue and back end.
// Depends on wtf8_pkg, wtf8_front, wtf8_queue and wtf8_back.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one raw byte per item with a
//   flag that marks the last byte of a stream. The result channel
//   (out_valid/out_ready) gives at most one item per byte: a 21-bit code
//   point with status 0, or an error with status 1 and code point 0.
//   out_stream_end is set on a result caused by the last byte of a stream.
//   Throughput: one byte per cycle while the receiver keeps up.
//   Path: an accepted byte is first written into the queue; from the head of
//   the queue the output register takes it and raises out_valid, and the
//   receiver takes it from the output register.
//   When the receiver stalls, the output register holds its item and the
//   queue absorbs up to two more bytes before in_ready drops.
//   After an error, no further result appears until reset.
//   Reset (rst_n low, synchronous) empties the queue, drops any pending
//   result and clears the sequence state and the error latch.
module wtf8_byte_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte_in,
  input  logic                         in_stream_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wtf8_pkg::POINT_W-1:0] out_code_point,
  output logic                         out_status,
  output logic                         out_stream_end
);
  import wtf8_pkg::*;

  q_item_t front_item;
  q_item_t q_head;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;

  assign in_ready = !q_full;

  // Classification of the incoming byte.
  wtf8_front u_front (
    .byte_in     (in_byte_in),
    .stream_last (in_stream_last),
    .item        (front_item)
  );

  // Decoupling queue.
  wtf8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Sequence decoding and result register.
  wtf8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_stream_end (out_stream_end)
  );

endmodule

// ===== rtl/wtf8_front.sv =====
// Front end: classifies each incoming byte and extracts its payload bits.
// Depends on wtf8_pkg for the byte class and queue item types.
module wtf8_front (
  input  logic [7:0]        byte_in,
  input  logic              stream_last,
  output wtf8_pkg::q_item_t item
);
  import wtf8_pkg::*;

  // Decide the class from the top bits and keep only the payload bits.
  always_comb begin
    item.last = stream_last;
    item.bits = '0;
    if (byte_in inside {[8'h00:8'h7F]}) begin
      item.cls  = CLS_ASCII;
      item.bits = byte_in[6:0];
    end else if (byte_in inside {[8'h80:8'hBF]}) begin
      item.cls  = CLS_CONT;
      item.bits = {1'b0, byte_in[5:0]};
    end else if (byte_in inside {[8'hC0:8'hDF]}) begin
      item.cls  = CLS_LEAD2;
      item.bits = {2'b00, byte_in[4:0]};
    end else if (byte_in inside {[8'hE0:8'hEF]}) begin
      item.cls  = CLS_LEAD3;
      item.bits = {3'b000, byte_in[3:0]};
    end else if (byte_in inside {[8'hF0:8'hF7]}) begin
      item.cls  = CLS_LEAD4;
      item.bits = {4'b0000, byte_in[2:0]};
    end else begin
      item.cls  = CLS_BAD;
    end
  end

endmodule

// ===== rtl/wtf8_queue.sv =====
// Short queue of classified bytes between the front end and the back end.
// Depends on wtf8_pkg for the item type and the queue depth.
module wtf8_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wtf8_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output wtf8_pkg::q_item_t head
);
  import wtf8_pkg::*;

  q_item_t         mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  // Pointer and fill count updates; the depth is a power of two so pointers wrap.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/wtf8_back.sv =====
// Back end: runs the sequence state and drives the registered result item.
// Depends on wtf8_pkg for the item type, byte classes and widths.
module wtf8_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  wtf8_pkg::q_item_t            q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wtf8_pkg::POINT_W-1:0] out_code_point,
  output logic                         out_status,
  output logic                         out_stream_end
);
  import wtf8_pkg::*;

  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [POINT_W-1:0] acc_r, acc_nxt;
  logic               err_r, err_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [POINT_W-1:0] code_r, code_nxt;
  logic               status_r, status_nxt;
  logic               end_r, end_nxt;
  logic [POINT_W-1:0] shifted;

  // Take the next item whenever the output register is free or being drained.
  assign q_pop   = !q_empty && (!ovalid_r || out_ready);
  assign shifted = {acc_r[POINT_W-7:0], q_head.bits[5:0]};

  assign out_valid      = ovalid_r;
  assign out_code_point = code_r;
  assign out_status     = status_r;
  assign out_stream_end = end_r;

  // Decode step for one item and the result it produces, if any.
  always_comb begin
    logic emit_err;
    logic emit_pt;
    logic [POINT_W-1:0] pt;
    emit_err   = 1'b0;
    emit_pt    = 1'b0;
    pt         = '0;
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    ovalid_nxt = ovalid_r && !out_ready;
    code_nxt   = code_r;
    status_nxt = status_r;
    end_nxt    = end_r;
    if (q_pop && !err_r) begin
      if (rem_r == '0) begin
        case (q_head.cls)
          CLS_ASCII: begin
            emit_pt = 1'b1;
            pt      = POINT_W'(q_head.bits);
          end
          CLS_LEAD2: begin
            rem_nxt  = REM_W'(1);
            acc_nxt  = POINT_W'(q_head.bits);
            emit_err = q_head.last;
          end
          CLS_LEAD3: begin
            rem_nxt  = REM_W'(2);
            acc_nxt  = POINT_W'(q_head.bits);
            emit_err = q_head.last;
          end
          CLS_LEAD4: begin
            rem_nxt  = REM_W'(3);
            acc_nxt  = POINT_W'(q_head.bits);
            emit_err = q_head.last;
          end
          default: begin
            emit_err = 1'b1;
          end
        endcase
      end else if (q_head.cls != CLS_CONT) begin
        emit_err = 1'b1;
      end else begin
        rem_nxt = rem_r - 1'b1;
        if (rem_r == REM_W'(1)) begin
          emit_pt = 1'b1;
          pt      = shifted;
          acc_nxt = '0;
        end else begin
          acc_nxt  = shifted;
          emit_err = q_head.last;
        end
      end
    end
    // An error clears the sequence and blocks all later items.
    if (emit_err) begin
      err_nxt    = 1'b1;
      rem_nxt    = '0;
      acc_nxt    = '0;
      ovalid_nxt = 1'b1;
      code_nxt   = '0;
      status_nxt = 1'b1;
      end_nxt    = q_head.last;
    end else if (emit_pt) begin
      ovalid_nxt = 1'b1;
      code_nxt   = pt;
      status_nxt = 1'b0;
      end_nxt    = q_head.last;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      acc_r    <= '0;
      err_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      acc_r    <= acc_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    status_r <= status_nxt;
    end_r    <= end_nxt;
  end

  // Once latched, the error stays until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error latch dropped without reset");

  // An error result is only shown once the latch is set.
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && status_r) |-> err_r)
    else $error("error result without latched error");

  // A latched error leaves no open sequence behind.
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (rem_r == '0))
    else $error("open sequence while error is latched");

  // Outside a sequence the accumulator is clear.
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r == '0) |-> (acc_r == '0))
    else $error("accumulator not clear between sequences");

endmodule

// ===== sim/wtf8_byte_decoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for wtf8_byte_decoder: byte stream in, code points out.
// Depends on wtf8_pkg and the decoder RTL; needs no files or arguments.

module wtf8_byte_decoder_test;

  import wtf8_pkg::*;

  localparam logic STATUS_POINT = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  localparam int unsigned DIRECTED_LEN = 26;
  localparam int unsigned RANDOM_ITEMS = 425;
  localparam int unsigned STALL_LIMIT  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [POINT_W-1:0] code_point;
    logic               status;
    logic               stream_end;
  } point_item_t;

  // One byte of stimulus, with a typed-in result where it is obvious.
  typedef struct packed {
    logic [7:0]  value;
    logic        last;
    logic        fixed;
    point_item_t want;
  } byte_row_t;

  // Ways to break the stream once the clean traffic is done.
  typedef enum logic [1:0] {
    TAIL_BAD_LEAD,
    TAIL_LONE_CONT,
    TAIL_LEAD_IN_SEQ,
    TAIL_END_IN_SEQ
  } error_tail_t;

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte_in     = 8'h00;
  logic               in_stream_last = 1'b0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [POINT_W-1:0] out_code_point;
  logic               out_status;
  logic               out_stream_end;

  // Predictor state: continuation bytes still due, bits so far, error latch.
  logic [1:0]         seq_left       = 2'd0;
  logic [POINT_W-1:0] seq_bits       = '0;
  logic               decode_locked  = 1'b0;

  point_item_t        expected_points[$];
  byte_row_t          stimulus_rows[$];
  int unsigned        fault_count    = 0;
  int unsigned        idle_cycles    = 0;
  bit                 steady         = 1'b0;

  // Directed stimulus: extremes of each sequence length and clean stream ends.
  byte_row_t directed_rows [DIRECTED_LEN] = '{
    '{8'h00, 1'b0, 1'b1, '{21'h000000, STATUS_POINT, 1'b0}},
    '{8'h7f, 1'b0, 1'b1, '{21'h00007f, STATUS_POINT, 1'b0}},
    '{8'h55, 1'b1, 1'b1, '{21'h000055, STATUS_POINT, 1'b1}},
    '{8'hc0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hdf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b1, '{21'h0007ff, STATUS_POINT, 1'b0}},
    '{8'he0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hef, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b1, '{21'h00ffff, STATUS_POINT, 1'b0}},
    '{8'hed, 1'b0, 1'b0, '0},
    '{8'ha0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'hf0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hf7, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b1, 1'b1, '{21'h1fffff, STATUS_POINT, 1'b1}},
    '{8'hc2, 1'b0, 1'b0, '0},
    '{8'ha9, 1'b0, 1'b0, '0}
  };

  wtf8_byte_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .in_stream_last (in_stream_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_stream_end (out_stream_end)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Cycles that either side waits before its next item.
  function automatic int unsigned idle_draw();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // Sets the error latch and returns the error result.
  function automatic point_item_t latch_error(input logic last);
    point_item_t r;
    decode_locked = 1'b1;
    seq_left      = 2'd0;
    seq_bits      = '0;
    r = '{'0, STATUS_ERROR, last};
    return r;
  endfunction

  // Advances the predictor by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output point_item_t r);
    r = '{'0, STATUS_POINT, last};
    if (decode_locked) return 1'b0;
    if (seq_left == 2'd0) begin
      // Invalid lead or lone continuation outside a sequence.
      if (b[7:3] == 5'b11111 || b[7:6] == 2'b10) begin
        r = latch_error(last);
        return 1'b1;
      end
      if (!b[7]) begin
        r.code_point = {13'd0, b};
        return 1'b1;
      end
      if (b[7:3] == 5'b11110) begin
        seq_left = 2'd3;
        seq_bits = {18'd0, b[2:0]};
      end else if (b[7:4] == 4'b1110) begin
        seq_left = 2'd2;
        seq_bits = {17'd0, b[3:0]};
      end else begin
        seq_left = 2'd1;
        seq_bits = {16'd0, b[4:0]};
      end
      if (last) begin
        r = latch_error(last);
        return 1'b1;
      end
      return 1'b0;
    end
    // Inside a sequence only continuation bytes are legal.
    if (b[7:6] != 2'b10) begin
      r = latch_error(last);
      return 1'b1;
    end
    seq_bits = {seq_bits[POINT_W-7:0], b[5:0]};
    seq_left = seq_left - 2'd1;
    if (seq_left == 2'd0) begin
      r.code_point = seq_bits;
      seq_bits = '0;
      return 1'b1;
    end
    if (last) begin
      r = latch_error(last);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic byte_row_t plain_row(input logic [7:0] value, input logic last);
    byte_row_t row;
    row = '{value, last, 1'b0, '0};
    return row;
  endfunction

  function automatic byte_row_t error_row(input logic [7:0] value, input logic last);
    byte_row_t row;
    row = '{value, last, 1'b1, '{'0, STATUS_ERROR, last}};
    return row;
  endfunction

  // Random lead byte for a sequence of len bytes (2 to 4).
  function automatic logic [7:0] lead_byte(input int unsigned len);
    logic [7:0] payload;
    payload = 8'($urandom_range(0, 255));
    case (len)
      2: return {3'b110, payload[4:0]};
      3: return {4'b1110, payload[3:0]};
      default: return {5'b11110, payload[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Drives one byte, waits for it to be taken, and records what it should yield.
  task automatic send_row(input byte_row_t row);
    int unsigned gap;
    point_item_t got;
    bit has_result;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_in     <= row.value;
    in_stream_last <= row.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_result = decode_byte(row.value, row.last, got);
    if (row.fixed) expected_points.push_back(row.want);
    else if (has_result) expected_points.push_back(got);
    @(negedge clk);
  endtask

  // Well-formed streams with random content; the last byte may close the stream.
  task automatic build_clean_traffic();
    int unsigned len;
    logic last;
    stimulus_rows.delete();
    while (stimulus_rows.size() < RANDOM_ITEMS) begin
      len  = $urandom_range(0, 9);
      last = ($urandom_range(0, 3) == 0);
      if (len < 3) begin
        stimulus_rows.push_back(plain_row({1'b0, 7'($urandom_range(0, 127))}, last));
      end else begin
        len = (len < 5) ? 2 : (len < 7) ? 3 : 4;
        stimulus_rows.push_back(plain_row(lead_byte(len), 1'b0));
        for (int k = 1; k < len; k++)
          stimulus_rows.push_back(plain_row(cont_byte(), (k == len - 1) ? last : 1'b0));
      end
    end
  endtask

  // One malformed case, picked at random, then bytes the latched error must swallow.
  task automatic build_error_tail();
    error_tail_t kind;
    int unsigned len;
    int unsigned conts;
    logic [7:0] bad;
    stimulus_rows.delete();
    kind  = error_tail_t'($urandom_range(0, 3));
    len   = $urandom_range(2, 4);
    conts = $urandom_range(0, len - 2);
    case (kind)
      TAIL_BAD_LEAD:
        stimulus_rows.push_back(error_row({5'b11111, 3'($urandom_range(0, 7))},
                                          1'($urandom_range(0, 1))));
      TAIL_LONE_CONT:
        stimulus_rows.push_back(error_row(cont_byte(), 1'($urandom_range(0, 1))));
      TAIL_LEAD_IN_SEQ: begin
        stimulus_rows.push_back(plain_row(lead_byte(len), 1'b0));
        repeat (conts) stimulus_rows.push_back(plain_row(cont_byte(), 1'b0));
        do bad = 8'($urandom_range(0, 255)); while (bad[7:6] == 2'b10);
        stimulus_rows.push_back(error_row(bad, 1'($urandom_range(0, 1))));
      end
      default: begin
        // Stream ends before the sequence is complete.
        if (conts == 0) begin
          stimulus_rows.push_back(error_row(lead_byte(len), 1'b1));
        end else begin
          stimulus_rows.push_back(plain_row(lead_byte(len), 1'b0));
          repeat (conts - 1) stimulus_rows.push_back(plain_row(cont_byte(), 1'b0));
          stimulus_rows.push_back(error_row(cont_byte(), 1'b1));
        end
      end
    endcase
    repeat ($urandom_range(3, 6))
      stimulus_rows.push_back(plain_row(8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1))));
  endtask

  // Result side: random stall before each item.
  initial begin : receiver
    int unsigned stall;
    forever begin
      @(negedge clk);
      stall = idle_draw();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    point_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result: code_point %h status %b stream_end %b",
               out_code_point, out_status, out_stream_end);
        fault_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, out_code_point);
          fault_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_status);
          fault_count++;
        end
        if (out_stream_end !== want.stream_end) begin
          $error("stream_end: expected %b, got %b", want.stream_end, out_stream_end);
          fault_count++;
        end
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, drain, random streams, one error.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_LEN; i++) send_row(directed_rows[i]);

    // Hold the sender off until every result has come back.
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    @(negedge clk);

    build_clean_traffic();
    for (int i = 0; i < stimulus_rows.size(); i++) begin
      steady = (i >= 150 && i < 230);
      send_row(stimulus_rows[i]);
    end
    steady = 1'b0;

    build_error_tail();
    for (int i = 0; i < stimulus_rows.size(); i++) send_row(stimulus_rows[i]);
    in_valid <= 1'b0;

    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
